/* rtl/core/pgd_pkg.sv */
// Shared types, constants and helper functions of the particle density grid.
// Used by pgd_ctrl, pgd_dp, pgd_store and the top level; depends on nothing.
package pgd_pkg;

	localparam int AXIS_CELLS_MAX = 32;
	localparam int COUNT_BITS     = 16;
	localparam int NUM_AXES       = 3;
	localparam int AXIS_BITS      = $clog2(AXIS_CELLS_MAX);
	localparam int SIZE_BITS      = $clog2(AXIS_CELLS_MAX + 1);
	localparam int ADDR_BITS      = NUM_AXES * AXIS_BITS;
	localparam int STORE_DEPTH    = AXIS_CELLS_MAX * AXIS_CELLS_MAX * AXIS_CELLS_MAX;

	localparam int POS_BITS       = 32;
	localparam int SCALE_BITS     = 32;
	localparam int PROD_BITS      = POS_BITS + SCALE_BITS;
	localparam int WHOLE_BITS     = PROD_BITS - 32;
	localparam int CELL_BITS      = 5;
	localparam int OUT_COUNT_BITS = 16;
	localparam int CFG_SIZE_BITS  = 6;
	localparam int CFG_DATA_BITS  = 32;
	localparam int CFG_INDEX_BITS = 3;

	localparam logic [CFG_SIZE_BITS-1:0]  SIZE_RESET     = CFG_SIZE_BITS'(32);
	localparam logic [SCALE_BITS-1:0]     SCALE_RESET    = SCALE_BITS'(32'h0001_0000);
	localparam logic [COUNT_BITS-1:0]     COUNT_MAX      = '1;
	localparam logic [OUT_COUNT_BITS-1:0] OUT_COUNT_MAX  = '1;
	localparam logic [1:0]                NB_LAST        = 2'd2;
	localparam logic [1:0]                MUL_LAST       = 2'd3;

	typedef logic [AXIS_BITS-1:0] pgd_cell_t;
	typedef logic [ADDR_BITS-1:0] pgd_addr_t;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_GRID_SIZE_X = 3'd0,
		REG_GRID_SIZE_Y = 3'd1,
		REG_GRID_SIZE_Z = 3'd2,
		REG_SCALE_X     = 3'd3,
		REG_SCALE_Y     = 3'd4,
		REG_SCALE_Z     = 3'd5
	} pgd_reg_t;

	typedef enum logic [1:0] {
		REQ_CLEAR   = 2'd0,
		REQ_DEPOSIT = 2'd1,
		REQ_READ    = 2'd2
	} pgd_req_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MUL,
		ST_CHECK,
		ST_DEP,
		ST_DRAIN,
		ST_READ,
		ST_DONE
	} pgd_state_t;

	typedef struct packed {
		logic      take;
		logic      mul_en;
		logic [1:0] mul_axis;
		logic      eval_en;
		logic [1:0] eval_axis;
		logic      clr_we;
		pgd_addr_t clr_addr;
		logic      nb_issue;
		logic [1:0] ox;
		logic [1:0] oy;
		logic [1:0] oz;
		logic      rd_issue;
		logic      finish;
	} pgd_cmd_t;

	typedef struct packed {
		logic drop;
		logic out_full;
	} pgd_status_t;

	typedef struct packed {
		logic      re;
		logic      inc;
		pgd_addr_t addr;
		logic      clr_we;
		pgd_addr_t clr_addr;
	} pgd_store_req_t;

	typedef struct packed {
		logic [COUNT_BITS-1:0] value;
		logic                  sat_hit;
	} pgd_store_rsp_t;

	// A size register of zero acts as one, a value above the store size acts as the store size.
	function automatic logic [SIZE_BITS-1:0] used_size(input logic [CFG_SIZE_BITS-1:0] r);
		logic [SIZE_BITS-1:0] s;
		priority if (r == '0) s = SIZE_BITS'(1);
		else if (int'(r) > AXIS_CELLS_MAX) s = SIZE_BITS'(AXIS_CELLS_MAX);
		else s = SIZE_BITS'(r);
		return s;
	endfunction

	function automatic logic [OUT_COUNT_BITS-1:0] count_to_out(input logic [COUNT_BITS-1:0] v);
		logic [OUT_COUNT_BITS-1:0] o;
		if (COUNT_BITS > OUT_COUNT_BITS && v > COUNT_BITS'(OUT_COUNT_MAX)) o = OUT_COUNT_MAX;
		else o = OUT_COUNT_BITS'(v);
		return o;
	endfunction

endpackage

/* rtl/core/pgd_store.sv */
// Count memory with a two-stage read-modify-write path and write forwarding.
// Depends on pgd_pkg for widths and the request/response structs.
module pgd_store (
	input  logic                    clk,
	input  logic                    arst_n,
	input  pgd_pkg::pgd_store_req_t req,
	output pgd_pkg::pgd_store_rsp_t rsp
);
	import pgd_pkg::*;

	logic [COUNT_BITS-1:0] mem [STORE_DEPTH];
	logic [COUNT_BITS-1:0] rdata_q;
	logic                  s2_valid_q;
	logic                  s2_inc_q;
	pgd_addr_t             s2_addr_q;
	logic                  last_v_q;
	pgd_addr_t             last_addr_q;
	logic [COUNT_BITS-1:0] last_data_q;

	logic [COUNT_BITS-1:0] cur;
	logic [COUNT_BITS-1:0] next_val;
	logic                  at_max;
	logic                  upd;
	logic                  we;
	pgd_addr_t             waddr;
	logic [COUNT_BITS-1:0] wdata;

	// The write of the previous cycle has not reached the registered read yet.
	assign cur      = (last_v_q && last_addr_q == s2_addr_q) ? last_data_q : rdata_q;
	assign at_max   = (cur == COUNT_MAX);
	assign next_val = at_max ? cur : cur + COUNT_BITS'(1);
	assign upd      = s2_valid_q & s2_inc_q;
	assign we       = req.clr_we | upd;
	assign waddr    = req.clr_we ? req.clr_addr : s2_addr_q;
	assign wdata    = req.clr_we ? '0 : next_val;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (req.re) begin
			rdata_q <= mem[req.addr];
		end
	end

	always_ff @(posedge clk) begin
		if (req.re) begin
			s2_addr_q <= req.addr;
		end
		if (upd) begin
			last_addr_q <= s2_addr_q;
			last_data_q <= next_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q <= 1'b0;
			s2_inc_q   <= 1'b0;
			last_v_q   <= 1'b0;
		end else begin
			s2_valid_q <= req.re;
			s2_inc_q   <= req.inc;
			if (req.clr_we) begin
				last_v_q <= 1'b0;
			end else if (upd) begin
				last_v_q <= 1'b1;
			end
		end
	end

	assign rsp.value   = cur;
	assign rsp.sat_hit = upd & at_max;

endmodule

/* rtl/core/pgd_dp.sv */
// Datapath: configuration registers, request capture, the shared position
// multiplier, neighbor index tables and the result register. Uses pgd_pkg.
module pgd_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [pgd_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [pgd_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	input  logic [1:0]                          req_type,
	input  logic [pgd_pkg::POS_BITS-1:0]        pos_x,
	input  logic [pgd_pkg::POS_BITS-1:0]        pos_y,
	input  logic [pgd_pkg::POS_BITS-1:0]        pos_z,
	input  logic [pgd_pkg::CELL_BITS-1:0]       cell_i,
	input  logic [pgd_pkg::CELL_BITS-1:0]       cell_j,
	input  logic [pgd_pkg::CELL_BITS-1:0]       cell_k,
	input  pgd_pkg::pgd_cmd_t                   cmd,
	output pgd_pkg::pgd_status_t                status,
	output pgd_pkg::pgd_store_req_t             st_req,
	input  pgd_pkg::pgd_store_rsp_t             st_rsp,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [pgd_pkg::OUT_COUNT_BITS-1:0]  cell_count,
	output logic                                dropped,
	output logic                                saturated
);
	import pgd_pkg::*;

	logic [CFG_SIZE_BITS-1:0]  size_q  [NUM_AXES];
	logic [SCALE_BITS-1:0]     scale_q [NUM_AXES];
	logic [1:0]                req_q;
	logic [POS_BITS-1:0]       pos_q   [NUM_AXES];
	pgd_cell_t                 rcell_q [NUM_AXES];
	logic                      read_ok_q;
	logic [PROD_BITS-1:0]      prod_s1;
	pgd_cell_t                 nb_q    [NUM_AXES][3];
	logic                      drop_q;
	logic                      sat_q;
	logic                      out_valid_q;
	logic [OUT_COUNT_BITS-1:0] cell_count_q;
	logic                      dropped_q;
	logic                      saturated_q;

	logic [SIZE_BITS-1:0]  size_e;
	logic [SIZE_BITS-1:0]  sm1_e;
	logic [WHOLE_BITS-1:0] whole_e;
	logic                  eq_e;
	logic                  gt_e;
	pgd_cell_t             cell_e;
	pgd_cell_t             lo_e;
	pgd_cell_t             hi_e;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				size_q[a]  <= SIZE_RESET;
				scale_q[a] <= SCALE_RESET;
			end
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GRID_SIZE_X: size_q[0]  <= cfg_data[CFG_SIZE_BITS-1:0];
				REG_GRID_SIZE_Y: size_q[1]  <= cfg_data[CFG_SIZE_BITS-1:0];
				REG_GRID_SIZE_Z: size_q[2]  <= cfg_data[CFG_SIZE_BITS-1:0];
				REG_SCALE_X:     scale_q[0] <= cfg_data[SCALE_BITS-1:0];
				REG_SCALE_Y:     scale_q[1] <= cfg_data[SCALE_BITS-1:0];
				REG_SCALE_Z:     scale_q[2] <= cfg_data[SCALE_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Integer part of the Q32.32 product, checked against the size in use.
	always_comb begin
		size_e  = used_size(size_q[cmd.eval_axis]);
		sm1_e   = size_e - SIZE_BITS'(1);
		whole_e = prod_s1[PROD_BITS-1 -: WHOLE_BITS];
		eq_e    = (whole_e == WHOLE_BITS'(size_e));
		gt_e    = (whole_e > WHOLE_BITS'(size_e));
		cell_e  = eq_e ? '0 : whole_e[AXIS_BITS-1:0];
		lo_e    = (cell_e == '0) ? AXIS_BITS'(sm1_e) : cell_e - AXIS_BITS'(1);
		hi_e    = (SIZE_BITS'(cell_e) == sm1_e) ? '0 : cell_e + AXIS_BITS'(1);
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			req_q      <= req_type;
			pos_q[0]   <= pos_x;
			pos_q[1]   <= pos_y;
			pos_q[2]   <= pos_z;
			rcell_q[0] <= AXIS_BITS'(cell_i);
			rcell_q[1] <= AXIS_BITS'(cell_j);
			rcell_q[2] <= AXIS_BITS'(cell_k);
			read_ok_q  <= (int'(cell_i) < AXIS_CELLS_MAX) && (int'(cell_j) < AXIS_CELLS_MAX)
				&& (int'(cell_k) < AXIS_CELLS_MAX);
		end
		if (cmd.mul_en) begin
			prod_s1 <= PROD_BITS'(pos_q[cmd.mul_axis]) * PROD_BITS'(scale_q[cmd.mul_axis]);
		end
		if (cmd.eval_en) begin
			nb_q[cmd.eval_axis][0] <= lo_e;
			nb_q[cmd.eval_axis][1] <= cell_e;
			nb_q[cmd.eval_axis][2] <= hi_e;
		end
		if (cmd.finish) begin
			cell_count_q <= (req_q == REQ_READ && read_ok_q) ? count_to_out(st_rsp.value) : '0;
			dropped_q    <= (req_q == REQ_DEPOSIT) & drop_q;
			saturated_q  <= (req_q == REQ_DEPOSIT) & sat_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drop_q      <= 1'b0;
			sat_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.take) begin
				drop_q <= 1'b0;
				sat_q  <= 1'b0;
			end else begin
				if (cmd.eval_en && gt_e) begin
					drop_q <= 1'b1;
				end
				if (st_rsp.sat_hit) begin
					sat_q <= 1'b1;
				end
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		st_req.re       = cmd.nb_issue | cmd.rd_issue;
		st_req.inc      = cmd.nb_issue;
		st_req.addr     = cmd.nb_issue
			? {nb_q[2][cmd.oz], nb_q[1][cmd.oy], nb_q[0][cmd.ox]}
			: {rcell_q[2], rcell_q[1], rcell_q[0]};
		st_req.clr_we   = cmd.clr_we;
		st_req.clr_addr = cmd.clr_addr;
	end

	assign status.drop     = drop_q;
	assign status.out_full = out_valid_q & ~out_ready;

	assign out_valid  = out_valid_q;
	assign cell_count = cell_count_q;
	assign dropped    = dropped_q;
	assign saturated  = saturated_q;

endmodule

/* rtl/core/pgd_ctrl.sv */
// Controller state machine: clearing sweep, multiply sequence, 27-cell
// neighbor walk, cell read and result hand-off. Uses pgd_pkg for states and commands.
module pgd_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic [1:0]           in_req,
	output logic                 in_ready,
	input  pgd_pkg::pgd_status_t status,
	output pgd_pkg::pgd_cmd_t    cmd
);
	import pgd_pkg::*;

	pgd_state_t state_q;
	pgd_state_t state_d;
	pgd_addr_t  clr_addr_q;
	logic       clr_reply_q;
	logic [1:0] mul_cnt_q;
	logic [1:0] ox_q;
	logic [1:0] oy_q;
	logic [1:0] oz_q;
	logic       nb_last;

	assign nb_last = (ox_q == NB_LAST) && (oy_q == NB_LAST) && (oz_q == NB_LAST);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (&clr_addr_q) state_d = clr_reply_q ? ST_DONE : ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) begin
					unique case (in_req)
						REQ_CLEAR:   state_d = ST_CLEAR;
						REQ_DEPOSIT: state_d = ST_MUL;
						REQ_READ:    state_d = ST_READ;
						default:     state_d = ST_DONE;
					endcase
				end
			end
			ST_MUL: begin
				if (mul_cnt_q == MUL_LAST) state_d = ST_CHECK;
			end
			ST_CHECK: state_d = status.drop ? ST_DONE : ST_DEP;
			ST_DEP: begin
				if (nb_last) state_d = ST_DRAIN;
			end
			ST_DRAIN: state_d = ST_DONE;
			ST_READ:  state_d = ST_DONE;
			ST_DONE: begin
				if (!status.out_full) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready      = (state_q == ST_IDLE);
		cmd           = '0;
		cmd.clr_addr  = clr_addr_q;
		cmd.ox        = ox_q;
		cmd.oy        = oy_q;
		cmd.oz        = oz_q;
		cmd.mul_axis  = mul_cnt_q;
		cmd.eval_axis = mul_cnt_q - 2'd1;
		unique case (state_q)
			ST_CLEAR: cmd.clr_we = 1'b1;
			ST_IDLE:  cmd.take = in_valid;
			ST_MUL: begin
				// Multiply axis n while the product of axis n-1 is checked.
				cmd.mul_en  = (mul_cnt_q != MUL_LAST);
				cmd.eval_en = (mul_cnt_q != 2'd0);
			end
			ST_DEP:  cmd.nb_issue = 1'b1;
			ST_READ: cmd.rd_issue = 1'b1;
			ST_DONE: cmd.finish = ~status.out_full;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_addr_q  <= '0;
			clr_reply_q <= 1'b0;
			mul_cnt_q   <= '0;
			ox_q        <= '0;
			oy_q        <= '0;
			oz_q        <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_addr_q <= clr_addr_q + ADDR_BITS'(1);
				if (&clr_addr_q) clr_reply_q <= 1'b0;
			end
			if (state_q == ST_IDLE && in_valid && in_req == REQ_CLEAR) begin
				clr_reply_q <= 1'b1;
			end
			if (state_q == ST_MUL) begin
				mul_cnt_q <= mul_cnt_q + 2'd1;
			end
			if (state_q == ST_DEP) begin
				if (oz_q == NB_LAST) begin
					oz_q <= '0;
					if (oy_q == NB_LAST) begin
						oy_q <= '0;
						ox_q <= (ox_q == NB_LAST) ? 2'd0 : ox_q + 2'd1;
					end else begin
						oy_q <= oy_q + 2'd1;
					end
				end else begin
					oz_q <= oz_q + 2'd1;
				end
			end
		end
	end

endmodule

/* rtl/core/particle_grid_density_deposit.sv */
// Top level of the 3D particle density grid: controller, datapath and count store.
// Depends on pgd_pkg, pgd_ctrl, pgd_dp and pgd_store.
//
//  Channel  Handshake             Payload
//  in       in_valid / in_ready   req_type, pos_x..pos_z, cell_i..cell_k
//  out      out_valid / out_ready cell_count, dropped, saturated
//  cfg      cfg_we                cfg_index, cfg_data
//
// A deposit does one read-modify-write on the single count memory for each of
// the 27 neighbor cells, a dropped deposit none; a clear writes one memory
// entry per cycle. After reset a clearing pass runs before the first request.
// A new request is accepted while the previous result still waits in the output
// register; a result stalled by out_ready holds the controller in its last state.
module particle_grid_density_deposit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [1:0]                          req_type,
	input  logic [pgd_pkg::POS_BITS-1:0]        pos_x,
	input  logic [pgd_pkg::POS_BITS-1:0]        pos_y,
	input  logic [pgd_pkg::POS_BITS-1:0]        pos_z,
	input  logic [pgd_pkg::CELL_BITS-1:0]       cell_i,
	input  logic [pgd_pkg::CELL_BITS-1:0]       cell_j,
	input  logic [pgd_pkg::CELL_BITS-1:0]       cell_k,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [pgd_pkg::OUT_COUNT_BITS-1:0]  cell_count,
	output logic                                dropped,
	output logic                                saturated,
	input  logic                                cfg_we,
	input  logic [pgd_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [pgd_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
	import pgd_pkg::*;

	pgd_cmd_t       cmd;
	pgd_status_t    status;
	pgd_store_req_t st_req;
	pgd_store_rsp_t st_rsp;

	pgd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_req   (req_type),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	pgd_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.req_type   (req_type),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.pos_z      (pos_z),
		.cell_i     (cell_i),
		.cell_j     (cell_j),
		.cell_k     (cell_k),
		.cmd        (cmd),
		.status     (status),
		.st_req     (st_req),
		.st_rsp     (st_rsp),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.cell_count (cell_count),
		.dropped    (dropped),
		.saturated  (saturated)
	);

	pgd_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (st_req),
		.rsp    (st_rsp)
	);

	// Only one request is in work at a time.
	a_one_request: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("request accepted while another is in work");

	a_clear_alone: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr_we |-> !st_req.re)
		else $error("store access during clearing pass");

	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!out_valid || out_ready))
		else $error("result written over a result not yet taken");

	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(dropped && saturated))
		else $error("dropped deposit reports saturation");

endmodule
